// ===== hdl/mhpq_pkg.sv =====
// Shared types and constants for the min-heap priority queue.
// No dependencies; imported by mhpq_ram and min_heap_priority_queue_top.
package mhpq_pkg;

  // Heap size and key format
  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Command codes
  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_LD,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } state_t;

  // Heap store write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [KEY_W-1:0]  data;
  } ram_wr_t;

  // Heap store read addresses (two ports)
  typedef struct packed {
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
  } ram_rd_t;

endpackage

// ===== hdl/mhpq_ram.sv =====
// Heap store: one write port, two read ports, registered read data.
// Depends on mhpq_pkg for sizes and port structs.
module mhpq_ram
  import mhpq_pkg::*;
(
  input  logic             clk,
  input  ram_wr_t          wr,
  input  ram_rd_t          rd,
  output logic [KEY_W-1:0] rdata_a,
  output logic [KEY_W-1:0] rdata_b
);

  logic [KEY_W-1:0] mem [CAPACITY];

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read ports, registered
  always_ff @(posedge clk) begin
    rdata_a <= mem[rd.addr_a];
    rdata_b <= mem[rd.addr_b];
  end

endmodule

// ===== hdl/min_heap_priority_queue_top.sv =====
// Binary min-heap priority queue: sequencer, root copy and result register.
// Depends on mhpq_pkg and mhpq_ram.
//
// Keys live in a 64-entry RAM as a 1-based complete binary tree; one command is
// worked at a time. A peek, a refused push or pop, or a pop of the last key goes
// straight to the done state with no RAM write. A push climbs the new key from the
// new last slot towards the root (at most 6 levels); a pop moves the last key to
// the root and sinks it towards the smaller child (at most 5 levels). Each level
// takes one RAM read and then one compare with write-back. The smallest key is held
// in a register beside the RAM. A finished result sits in an output register, so
// the next command can be taken while it waits.
module min_heap_priority_queue_top
  import mhpq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_command,
  input  logic signed [KEY_W-1:0] in_key,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [KEY_W-1:0] out_removed_key,
  output logic signed [KEY_W-1:0] out_min_key,
  output logic [CNT_W-1:0]        out_entry_count,
  output logic [1:0]              out_status
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [KEY_W-1:0]    removed_r, removed_nxt;
  status_t             status_r, status_nxt;
  logic [KEY_W-1:0]    root_r;
  logic                out_valid_r;
  logic [KEY_W-1:0]    out_removed_r, out_min_r;
  logic [CNT_W-1:0]    out_cnt_r;
  logic [1:0]          out_status_r;
  logic                out_load;

  ram_wr_t             wr;
  ram_rd_t             rd;
  logic [KEY_W-1:0]    rdata_a, rdata_b;

  logic [CNT_W:0]      left_idx, right_idx;
  logic                has_left, has_right;
  logic                left_lt, right_lt_best;
  logic [KEY_W-1:0]    best_val;

  mhpq_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Child indices of the hole during sift-down
  assign left_idx  = {idx_r, 1'b0};
  assign right_idx = {idx_r, 1'b1};
  assign has_left  = left_idx  <= {1'b0, cnt_r};
  assign has_right = right_idx <= {1'b0, cnt_r};

  // Smaller-child selection; ties keep the left child and the upper node
  assign left_lt       = $signed(rdata_a) < $signed(key_r);
  assign best_val      = left_lt ? rdata_a : key_r;
  assign right_lt_best = has_right && ($signed(rdata_b) < $signed(best_val));

  assign in_ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // Next state, datapath and RAM control
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    key_nxt     = key_r;
    removed_nxt = removed_r;
    status_nxt  = status_r;
    wr          = '0;
    rd.addr_a   = ADDR_W'(idx_r - ONE_CNT);
    rd.addr_b   = ADDR_W'(idx_r - ONE_CNT);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          removed_nxt = '0;
          status_nxt  = ST_OK;
          state_nxt   = S_DONE;
          priority if (in_command == CMD_PUSH) begin
            if (cnt_r == CAP_CNT) begin
              status_nxt = ST_FULL;
            end else begin
              cnt_nxt   = cnt_r + ONE_CNT;
              idx_nxt   = cnt_r + ONE_CNT;
              key_nxt   = in_key;
              state_nxt = S_UP_RD;
            end
          end else if (in_command == CMD_POP) begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              removed_nxt = root_r;
              cnt_nxt     = cnt_r - ONE_CNT;
              idx_nxt     = ONE_CNT;
              // fetch the last entry, it refills the root
              rd.addr_a   = ADDR_W'(cnt_r - ONE_CNT);
              if (cnt_r != ONE_CNT) begin
                state_nxt = S_POP_LD;
              end
            end
          end
        end
      end
      S_UP_RD: begin
        // hole at the root: settle there, else fetch the parent
        if (idx_r == ONE_CNT) begin
          wr.en     = 1'b1;
          wr.addr   = '0;
          wr.data   = key_r;
          state_nxt = S_DONE;
        end else begin
          rd.addr_a = ADDR_W'((idx_r >> 1) - ONE_CNT);
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        wr.en   = 1'b1;
        wr.addr = ADDR_W'(idx_r - ONE_CNT);
        if ($signed(key_r) < $signed(rdata_a)) begin
          // parent moves down into the hole
          wr.data   = rdata_a;
          idx_nxt   = idx_r >> 1;
          state_nxt = S_UP_RD;
        end else begin
          wr.data   = key_r;
          state_nxt = S_DONE;
        end
      end
      S_POP_LD: begin
        key_nxt   = rdata_a;
        state_nxt = S_DN_RD;
      end
      S_DN_RD: begin
        if (!has_left) begin
          wr.en     = 1'b1;
          wr.addr   = ADDR_W'(idx_r - ONE_CNT);
          wr.data   = key_r;
          state_nxt = S_DONE;
        end else begin
          rd.addr_a = ADDR_W'(left_idx - 1'b1);
          rd.addr_b = ADDR_W'(left_idx);
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        wr.en   = 1'b1;
        wr.addr = ADDR_W'(idx_r - ONE_CNT);
        priority if (right_lt_best) begin
          wr.data   = rdata_b;
          idx_nxt   = CNT_W'(right_idx);
          state_nxt = S_DN_RD;
        end else if (left_lt) begin
          wr.data   = rdata_a;
          idx_nxt   = CNT_W'(left_idx);
          state_nxt = S_DN_RD;
        end else begin
          wr.data   = key_r;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers and root copy
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    key_r     <= key_nxt;
    removed_r <= removed_nxt;
    status_r  <= status_nxt;
    if (wr.en && (wr.addr == '0)) begin
      root_r <= wr.data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_removed_r <= removed_r;
      out_min_r     <= (cnt_r != '0) ? root_r : '0;
      out_cnt_r     <= cnt_r;
      out_status_r  <= status_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_removed_key = out_removed_r;
  assign out_min_key     = out_min_r;
  assign out_entry_count = out_cnt_r;
  assign out_status      = out_status_r;

`ifndef SYNTHESIS
  // Count never passes capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_CNT)
    else $error("held count above capacity");

  // An accepted push with room grows the count by one
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_command == CMD_PUSH) && (cnt_r != CAP_CNT))
    |=> (cnt_r == $past(cnt_r) + ONE_CNT))
    else $error("push did not grow the count");

  // A refused push reports a full heap
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (status_r == ST_FULL)) |-> (cnt_r == CAP_CNT))
    else $error("full status with room left");

  // A refused pop reports an empty heap and removes nothing
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (status_r == ST_EMPTY)) |-> ((cnt_r == '0) && (removed_r == '0)))
    else $error("empty status inconsistent");

  // The store is only written while a sift is in progress
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> ((state_r == S_UP_RD) || (state_r == S_UP_CMP) ||
               (state_r == S_DN_RD) || (state_r == S_DN_CMP)))
    else $error("heap write outside a sift");
`endif

endmodule

// ===== tb/min_heap_priority_queue_top_tb.sv =====
// Testbench for the min-heap priority queue: directed edge cases, a full fill begun under
// a long output stall, then random command streams, all checked against a predictor.
// Depends on mhpq_pkg and min_heap_priority_queue_top.
module min_heap_priority_queue_top_tb;
  import mhpq_pkg::*;

  // Spare command code; the block treats it as a peek
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int WATCHDOG_CYCLES = 400000;
  localparam int MISMATCH_SHOWN = 10;

  // Expected contents of one result transfer
  typedef struct packed {
    logic signed [KEY_W-1:0] removed_key;
    logic signed [KEY_W-1:0] min_key;
    logic [CNT_W-1:0]        entry_count;
    status_t                 status;
  } heap_reply_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_command;
  logic signed [KEY_W-1:0] in_key;
  logic out_valid;
  logic out_ready;
  logic signed [KEY_W-1:0] out_removed_key;
  logic signed [KEY_W-1:0] out_min_key;
  logic [CNT_W-1:0] out_entry_count;
  logic [1:0] out_status;

  // Predictor state: 1-based heap and its fill
  logic signed [KEY_W-1:0] heap_keys [1:CAPACITY];
  int heap_fill;
  heap_reply_t replies_due [$];

  // Idling controls and the long output hold-off request
  bit sender_idles;
  bit receiver_idles;
  int holdoff_request;

  // Run statistics
  int mismatches;
  int replies_checked;
  int pushes_taken, pushes_refused, pops_taken, pops_refused, peeks_taken;
  int deepest_fill;

  min_heap_priority_queue_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_removed_key (out_removed_key),
    .out_min_key     (out_min_key),
    .out_entry_count (out_entry_count),
    .out_status      (out_status)
  );

  always #6 clk = ~clk;

  // Apply one accepted command to the predicted heap and queue its reply
  function automatic void heap_apply_command(input logic [1:0] cmd,
                                             input logic signed [KEY_W-1:0] key);
    heap_reply_t r;
    int i;
    int child;
    int smaller;
    bit moving;
    logic signed [KEY_W-1:0] t;
    r = '0;
    r.status = ST_OK;
    if (cmd == CMD_PUSH) begin
      if (heap_fill >= CAPACITY) begin
        r.status = ST_FULL;
        pushes_refused++;
      end else begin
        // append, then climb while the parent is strictly greater
        heap_fill++;
        heap_keys[heap_fill] = key;
        i = heap_fill;
        while (i > 1 && heap_keys[i] < heap_keys[i / 2]) begin
          t = heap_keys[i];
          heap_keys[i] = heap_keys[i / 2];
          heap_keys[i / 2] = t;
          i = i / 2;
        end
        pushes_taken++;
      end
    end else if (cmd == CMD_POP) begin
      if (heap_fill == 0) begin
        r.status = ST_EMPTY;
        pops_refused++;
      end else begin
        // last entry to the root, then sink towards the smaller child; ties stay put
        r.removed_key = heap_keys[1];
        heap_keys[1] = heap_keys[heap_fill];
        heap_fill--;
        i = 1;
        moving = 1'b1;
        while (moving && i <= heap_fill / 2) begin
          smaller = i;
          child = 2 * i;
          if (heap_keys[child] < heap_keys[smaller]) smaller = child;
          if (child + 1 <= heap_fill && heap_keys[child + 1] < heap_keys[smaller])
            smaller = child + 1;
          if (smaller == i) begin
            moving = 1'b0;
          end else begin
            t = heap_keys[i];
            heap_keys[i] = heap_keys[smaller];
            heap_keys[smaller] = t;
            i = smaller;
          end
        end
        pops_taken++;
      end
    end else begin
      peeks_taken++;
    end
    r.min_key = (heap_fill > 0) ? heap_keys[1] : '0;
    r.entry_count = CNT_W'(heap_fill);
    if (heap_fill > deepest_fill) deepest_fill = heap_fill;
    replies_due.insert(replies_due.size(), r);
  endfunction

  // Offer one command from a falling edge; returns at the falling edge after the transfer.
  // Valid is left high so a following call can present the next item without a dip.
  task automatic send_command(input logic [1:0] cmd, input logic signed [KEY_W-1:0] key);
    int gap;
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_key     <= key;
    do @(posedge clk); while (!in_ready);
    heap_apply_command(cmd, key);
    @(negedge clk);
  endtask

  // Lower valid when no item follows straight away
  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  // Lower valid, then wait for every outstanding reply to be checked
  task automatic wait_drained();
    stop_sending();
    while (replies_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
  endtask

  // Key mix: full range, a narrow band for ties, the two extremes and keys just above the minimum
  function automatic logic signed [KEY_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return $urandom;
    if (roll < 80) return KEY_W'($signed($urandom_range(0, 16)) - 8);
    if (roll < 88) return {1'b0, {(KEY_W-1){1'b1}}};
    if (roll < 96) return {1'b1, {(KEY_W-1){1'b0}}};
    return {1'b1, (KEY_W-1)'($urandom_range(0, 7))};
  endfunction

  function automatic logic [1:0] pick_command(input int push_pct, input int pop_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) return CMD_PUSH;
    if (roll < push_pct + pop_pct) return CMD_POP;
    if (roll < 97) return CMD_PEEK;
    return CMD_SPARE;
  endfunction

  // Extremes, empty refusals, the spare code and equal keys
  task automatic test_directed_edges();
    send_command(CMD_POP, '0);
    send_command(CMD_PEEK, '0);
    send_command(CMD_SPARE, 32'sh1234_5678);
    send_command(CMD_PUSH, 32'sh7FFF_FFFF);
    send_command(CMD_PUSH, 32'sh8000_0000);
    send_command(CMD_PEEK, 32'shFFFF_FFFF);
    send_command(CMD_PUSH, 32'sh0000_0000);
    send_command(CMD_PUSH, 32'shFFFF_FFFF);
    send_command(CMD_PUSH, 32'sh0000_0001);
    send_command(CMD_PUSH, 32'sh0000_0005);
    send_command(CMD_PUSH, 32'sh0000_0005);
    send_command(CMD_PUSH, 32'sh8000_0000);
    send_command(CMD_SPARE, 32'shFFFF_FFFF);
    repeat (8) send_command(CMD_POP, 32'shA5A5_A5A5);
    send_command(CMD_POP, '0);
    send_command(CMD_PEEK, '0);
    wait_drained();
  endtask

  // Start a long receiver hold-off, fill to capacity, refuse further pushes, then empty it
  task automatic test_fill_under_backpressure();
    holdoff_request = 300;
    repeat (CAPACITY) send_command(CMD_PUSH, pick_key());
    send_command(CMD_PUSH, 32'sh8000_0000);
    send_command(CMD_PUSH, $urandom);
    send_command(CMD_PEEK, '0);
    repeat (CAPACITY) send_command(CMD_POP, $urandom);
    send_command(CMD_POP, '0);
    wait_drained();
  endtask

  // Random segments biased towards growth, shrinkage or balance
  task automatic test_random_mix(input int item_total);
    int sent;
    int seg_len;
    int bias;
    int push_pct;
    int pop_pct;
    sent = 0;
    while (sent < item_total) begin
      seg_len = $urandom_range(30, 120);
      if (seg_len > item_total - sent) seg_len = item_total - sent;
      bias = $urandom_range(0, 2);
      push_pct = (bias == 0) ? 75 : (bias == 1) ? 20 : 45;
      pop_pct  = (bias == 0) ? 15 : (bias == 1) ? 70 : 42;
      // on each side, a quarter of segments run with no idling at all
      sender_idles   = ($urandom_range(0, 3) != 0);
      receiver_idles = ($urandom_range(0, 3) != 0);
      repeat (seg_len) begin
        send_command(pick_command(push_pct, pop_pct), pick_key());
        sent++;
      end
    end
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_steady_stream(input int item_total);
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    repeat (item_total) send_command(pick_command(48, 40), pick_key());
    wait_drained();
  endtask

  // Receiver: long hold-off on request, otherwise random stall bursts
  initial begin : drive_out_ready
    int holdoff_left;
    int stall_left;
    holdoff_left = 0;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_request > 0) begin
        holdoff_left = holdoff_request;
        holdoff_request = 0;
      end
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest outstanding reply
  always @(posedge clk) begin : check_replies
    heap_reply_t due;
    if (rst_n && out_valid && out_ready) begin
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MISMATCH_SHOWN)
          $display("ERROR: result with nothing outstanding: removed %0d min %0d count %0d st %0d",
                   out_removed_key, out_min_key, out_entry_count, out_status);
      end else begin
        due = replies_due.pop_front();
        replies_checked++;
        if (out_removed_key !== due.removed_key || out_min_key !== due.min_key ||
            out_entry_count !== due.entry_count || out_status !== due.status) begin
          mismatches++;
          if (mismatches <= MISMATCH_SHOWN)
            $display("ERROR: reply %0d exp removed %0d min %0d count %0d st %0d, got %0d %0d %0d %0d",
                     replies_checked, due.removed_key, due.min_key, due.entry_count,
                     due.status, out_removed_key, out_min_key, out_entry_count, out_status);
        end
      end
    end
  end

  // Guard against a hung handshake
  initial begin : watchdog
    repeat (WATCHDOG_CYCLES) @(posedge clk);
    $display("Timeout: %0d replies still outstanding", replies_due.size());
    $display("min_heap_priority_queue_top_tb NOT OK");
    $finish;
  end

  initial begin : run_tests
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_PEEK;
    in_key = '0;
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    holdoff_request = 0;
    heap_fill = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_edges();
    test_fill_under_backpressure();
    test_random_mix(950);
    test_steady_stream(250);

    $display("Covered %0d pushes (%0d refused full), %0d pops (%0d refused empty), %0d peeks",
             pushes_taken, pushes_refused, pops_taken, pops_refused, peeks_taken);
    $display("Deepest fill %0d of %0d keys; %0d replies checked, %0d mismatches",
             deepest_fill, CAPACITY, replies_checked, mismatches);
    if (mismatches == 0 && replies_due.size() == 0)
      $display("min_heap_priority_queue_top_tb OK");
    else
      $display("min_heap_priority_queue_top_tb NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mhpq_pkg.sv
hdl/mhpq_ram.sv
hdl/min_heap_priority_queue_top.sv
tb/min_heap_priority_queue_top_tb.sv
